// ===== hw/rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and fixed field widths for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  // fixed field widths of the stream words
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned IN_PRIO_W = 8;
  localparam int unsigned OCC_W     = 5;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;

  // action codes carried on in_tuser
  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_DEQUEUE = 1'b1;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic enq;
    logic deq;
  } spq_cmd_t;

endpackage

// ===== hw/rtl/sorted_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded priority queue built as a chain of slots kept in sorted order.
// Results are registered: an accepted word's result is in the output
// register in the cycle after. Throughput: one word per cycle while the
// output is taken; all slots update in parallel from their neighbours.
// Reset clears all slot valid flags, fill count, output valid; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
  parameter int unsigned CAPACITY      = 16,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [spq_pkg::IN_DATA_W-1:0]     in_tdata,  // item_value[31:0], item_priority[39:32]
  input  logic                              in_tuser,  // action
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [spq_pkg::OUT_DATA_W-1:0]    out_tdata  // out_value[31:0], empty_error[32],
                                                       // full_drop[33], occupancy[38:34],
                                                       // zero[39]
);
  import spq_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // chain signals, index 0 is the head
  logic                     cell_valid [CAPACITY];
  logic [VALUE_W-1:0]       cell_value [CAPACITY];
  logic [PRIORITY_BITS-1:0] cell_prio  [CAPACITY];
  logic                     cell_stay  [CAPACITY];

  logic                     accept;
  logic                     empty, full;
  logic [VALUE_W-1:0]       new_value;
  logic [PRIORITY_BITS-1:0] new_prio;
  logic [39:0]              prio_ext;
  spq_cmd_t                 cmd;

  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [31:0]              count_ext;
  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]    out_data_r, out_data_nxt;
  logic [VALUE_W-1:0]       res_value;
  logic                     res_empty, res_full;

  // output register frees up as it is taken
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // unpack the input word, priority taken in its low bits
  assign new_value = in_tdata[VALUE_W-1:0];
  assign prio_ext  = {{(40 - IN_PRIO_W){1'b0}}, in_tdata[VALUE_W +: IN_PRIO_W]};
  assign new_prio  = prio_ext[PRIORITY_BITS-1:0];

  assign empty = !cell_valid[0];
  assign full  = cell_valid[CAPACITY-1];

  // command to the chain
  always_comb begin
    cmd.enq = accept && (in_tuser == ACT_ENQUEUE) && !full;
    cmd.deq = accept && (in_tuser == ACT_DEQUEUE) && !empty;
  end

  // row of slots
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     l_valid, l_stay, r_valid;
    logic [VALUE_W-1:0]       l_value, r_value;
    logic [PRIORITY_BITS-1:0] l_prio, r_prio;

    if (i == 0) begin : g_head
      // nothing ranks ahead of the head slot
      assign l_valid = 1'b0;
      assign l_value = '0;
      assign l_prio  = '0;
      assign l_stay  = 1'b1;
    end else begin : g_mid
      assign l_valid = cell_valid[i-1];
      assign l_value = cell_value[i-1];
      assign l_prio  = cell_prio[i-1];
      assign l_stay  = cell_stay[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_value = '0;
      assign r_prio  = '0;
    end else begin : g_body
      assign r_valid = cell_valid[i+1];
      assign r_value = cell_value[i+1];
      assign r_prio  = cell_prio[i+1];
    end

    spq_cell #(
      .PRIORITY_BITS(PRIORITY_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .new_value  (new_value),
      .new_prio   (new_prio),
      .left_valid (l_valid),
      .left_value (l_value),
      .left_prio  (l_prio),
      .left_stay  (l_stay),
      .right_valid(r_valid),
      .right_value(r_value),
      .right_prio (r_prio),
      .valid      (cell_valid[i]),
      .value      (cell_value[i]),
      .prio       (cell_prio[i]),
      .stay       (cell_stay[i])
    );
  end

  // fill count after this word
  always_comb begin
    count_nxt = count_r;
    if (cmd.enq) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.deq) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // result word
  always_comb begin
    res_value = cmd.deq ? cell_value[0] : '0;
    res_empty = accept && (in_tuser == ACT_DEQUEUE) && empty;
    res_full  = accept && (in_tuser == ACT_ENQUEUE) && full;
    count_ext = 32'(count_nxt);
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {1'b0, count_ext[OCC_W-1:0], res_full, res_empty, res_value};
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hw/rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: keeps its entry, takes the new pair, takes
// the entry of its left neighbour on insert, or of its right on removal.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  spq_pkg::spq_cmd_t            cmd,
  input  logic [spq_pkg::VALUE_W-1:0]  new_value,
  input  logic [PRIORITY_BITS-1:0]     new_prio,
  // left neighbour (towards the head)
  input  logic                         left_valid,
  input  logic [spq_pkg::VALUE_W-1:0]  left_value,
  input  logic [PRIORITY_BITS-1:0]     left_prio,
  input  logic                         left_stay,
  // right neighbour (towards the tail)
  input  logic                         right_valid,
  input  logic [spq_pkg::VALUE_W-1:0]  right_value,
  input  logic [PRIORITY_BITS-1:0]     right_prio,
  // this slot
  output logic                         valid,
  output logic [spq_pkg::VALUE_W-1:0]  value,
  output logic [PRIORITY_BITS-1:0]     prio,
  output logic                         stay
);
  import spq_pkg::*;

  logic                     valid_r, valid_nxt;
  logic [VALUE_W-1:0]       value_r, value_nxt;
  logic [PRIORITY_BITS-1:0] prio_r, prio_nxt;

  // entry ranks ahead of the new pair and holds its place
  assign stay = valid_r && (prio_r >= new_prio);

  // next entry of the slot
  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    prio_nxt  = prio_r;
    if (cmd.enq && !stay) begin
      if (left_stay) begin
        valid_nxt = 1'b1;
        value_nxt = new_value;
        prio_nxt  = new_prio;
      end else begin
        valid_nxt = left_valid;
        value_nxt = left_value;
        prio_nxt  = left_prio;
      end
    end else if (cmd.deq) begin
      valid_nxt = right_valid;
      value_nxt = right_value;
      prio_nxt  = right_prio;
    end
  end

  // valid flag is control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    prio_r  <= prio_nxt;
  end

  assign valid = valid_r;
  assign value = value_r;
  assign prio  = prio_r;

endmodule

// ===== test/sorted_priority_queue_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_core_tb
// Drives enqueue and dequeue words into the priority queue with random gaps
// and output stalls, predicts each result word from a local copy of the
// sorted slot contents, and checks every result field in arrival order.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core_tb;
  import spq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned PRIO_BITS   = 8;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_PRINTS  = 40;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               empty_error;
    logic               full_drop;
    logic [OCC_W-1:0]   occupancy;
  } result_word_t;

  // one row of the directed table; the expectation is used only when fixed
  typedef struct {
    logic               action;
    logic [VALUE_W-1:0] value;
    logic [IN_PRIO_W-1:0] prio;
    bit                 fixed;
    result_word_t       fixed_result;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;   // item_value[31:0], item_priority[39:32]
  logic in_tuser;                   // action
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata; // out_value[31:0], empty_error[32], full_drop[33],
                                    // occupancy[38:34], zero[39]

  // local copy of the sorted slots, head at index 0
  logic [VALUE_W-1:0]   slot_val_copy  [QUEUE_DEPTH];
  logic [IN_PRIO_W-1:0] slot_prio_copy [QUEUE_DEPTH];
  int unsigned          stored_count;

  result_word_t pending_results [$];
  stim_row_t    directed_rows [$];
  int unsigned  mismatch_count;
  int unsigned  cycle_count;
  bit           calm;

  sorted_priority_queue_core #(
    .CAPACITY      (QUEUE_DEPTH),
    .PRIORITY_BITS (PRIO_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // apply one accepted word to the slot copy and return its result
  function automatic result_word_t predict_queue_result(input logic action,
                                                        input logic [VALUE_W-1:0] value,
                                                        input logic [IN_PRIO_W-1:0] prio);
    result_word_t res;
    logic [IN_PRIO_W-1:0] p;
    int unsigned pos;
    res = '0;
    p = prio & IN_PRIO_W'((64'd1 << PRIO_BITS) - 1);
    if (action == ACT_ENQUEUE) begin
      if (stored_count >= QUEUE_DEPTH) begin
        res.full_drop = 1'b1;
      end else begin
        // insert behind every entry of greater or equal priority
        pos = 0;
        while (pos < stored_count && slot_prio_copy[pos] >= p) pos++;
        for (int i = stored_count; i > pos; i--) begin
          slot_val_copy[i]  = slot_val_copy[i-1];
          slot_prio_copy[i] = slot_prio_copy[i-1];
        end
        slot_val_copy[pos]  = value;
        slot_prio_copy[pos] = p;
        stored_count++;
      end
    end else begin
      if (stored_count == 0) begin
        res.empty_error = 1'b1;
      end else begin
        res.value = slot_val_copy[0];
        for (int i = 0; i + 1 < stored_count; i++) begin
          slot_val_copy[i]  = slot_val_copy[i+1];
          slot_prio_copy[i] = slot_prio_copy[i+1];
        end
        stored_count--;
      end
    end
    res.occupancy = OCC_W'(stored_count);
    return res;
  endfunction

  task automatic add_row(input logic action, input logic [VALUE_W-1:0] value,
                         input logic [IN_PRIO_W-1:0] prio, input bit fixed,
                         input logic [VALUE_W-1:0] exp_value, input logic exp_empty,
                         input logic exp_full, input logic [OCC_W-1:0] exp_occ);
    stim_row_t row;
    row.action = action;
    row.value  = value;
    row.prio   = prio;
    row.fixed  = fixed;
    row.fixed_result = '{value: exp_value, empty_error: exp_empty, full_drop: exp_full,
                         occupancy: exp_occ};
    directed_rows.push_back(row);
  endtask

  // present one word after a random gap and hold it until accepted
  task automatic send_word(input logic action, input logic [VALUE_W-1:0] value,
                           input logic [IN_PRIO_W-1:0] prio, input bit fixed,
                           input result_word_t fixed_result);
    int unsigned gap;
    result_word_t predicted;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= action;
    in_tdata  <= {prio, value};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = predict_queue_result(action, value, prio);
    pending_results.push_back(fixed ? fixed_result : predicted);
  endtask

  // result side: random stalls, compare against the oldest expectation
  initial begin
    int unsigned stall;
    result_word_t got;
    result_word_t want;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got = '{value: out_tdata[31:0], empty_error: out_tdata[32], full_drop: out_tdata[33],
              occupancy: out_tdata[38:34]};
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %h", out_tdata));
      end else begin
        want = pending_results.pop_front();
        if (got.value !== want.value)
          report_mismatch($sformatf("out_value %h, expected %h", got.value, want.value));
        if (got.empty_error !== want.empty_error)
          report_mismatch($sformatf("empty_error %b, expected %b", got.empty_error,
                                    want.empty_error));
        if (got.full_drop !== want.full_drop)
          report_mismatch($sformatf("full_drop %b, expected %b", got.full_drop,
                                    want.full_drop));
        if (got.occupancy !== want.occupancy)
          report_mismatch($sformatf("occupancy %0d, expected %0d", got.occupancy,
                                    want.occupancy));
        if (out_tdata[39] !== 1'b0)
          report_mismatch("padding bit not zero");
      end
    end
  end

  // stimulus
  initial begin
    int unsigned enq_pct;
    int unsigned prio_mode;
    logic act;
    logic [VALUE_W-1:0] val;
    logic [IN_PRIO_W-1:0] pri;
    mismatch_count = 0;
    cycle_count    = 0;
    stored_count   = 0;
    calm           = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= ACT_ENQUEUE;
    in_tdata  <= '0;

    // dequeue on empty, extremes, tie ordering, fill to capacity, drop, drain a few
    add_row(ACT_DEQUEUE, 32'h0000_0000, 8'h00, 1, 32'h0, 1'b1, 1'b0, 5'd0);
    add_row(ACT_ENQUEUE, 32'h7fff_ffff, 8'hff, 1, 32'h0, 1'b0, 1'b0, 5'd1);
    add_row(ACT_ENQUEUE, 32'h8000_0000, 8'h00, 0, '0, 1'b0, 1'b0, '0);
    add_row(ACT_ENQUEUE, 32'hffff_ffff, 8'hff, 0, '0, 1'b0, 1'b0, '0);
    add_row(ACT_ENQUEUE, 32'h0000_0000, 8'h80, 0, '0, 1'b0, 1'b0, '0);
    add_row(ACT_DEQUEUE, 32'hffff_ffff, 8'hff, 0, '0, 1'b0, 1'b0, '0);
    for (int i = 0; i < 13; i++)
      add_row(ACT_ENQUEUE, 32'h1000_0000 + i, IN_PRIO_W'((i * 37) % 5 == 0 ? 8'hff : i * 19),
              0, '0, 1'b0, 1'b0, '0);
    add_row(ACT_ENQUEUE, 32'h5555_aaaa, 8'hff, 1, 32'h0, 1'b0, 1'b1, 5'd16);
    for (int i = 0; i < 4; i++)
      add_row(ACT_DEQUEUE, 32'h0, 8'h00, 0, '0, 1'b0, 1'b0, '0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_word(directed_rows[i].action, directed_rows[i].value, directed_rows[i].prio,
                directed_rows[i].fixed, directed_rows[i].fixed_result);

    // random blocks with a drifting enqueue share so the queue swings full and empty
    for (int blk = 0; blk < 33; blk++) begin
      case ($urandom_range(0, 4))
        0: enq_pct = 10;
        1: enq_pct = 35;
        2: enq_pct = 50;
        3: enq_pct = 65;
        default: enq_pct = 90;
      endcase
      prio_mode = $urandom_range(0, 2);
      calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 50; k++) begin
        act = ($urandom_range(0, 99) < enq_pct) ? ACT_ENQUEUE : ACT_DEQUEUE;
        if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 3))
            0: val = 32'h0000_0000;
            1: val = 32'h7fff_ffff;
            2: val = 32'h8000_0000;
            default: val = 32'hffff_ffff;
          endcase
        end else begin
          val = $urandom;
        end
        // narrow priorities give many ties
        case (prio_mode)
          0: pri = IN_PRIO_W'($urandom_range(0, 3));
          1: pri = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hff;
          default: pri = IN_PRIO_W'($urandom);
        endcase
        send_word(act, val, pri, 0, '0);
      end
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sorted_priority_queue_core.f =====
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue_core.sv
test/sorted_priority_queue_core_tb.sv
